// ===== rtl/mdt_pkg.sv =====
// Package for the multi-delimiter tokenizer: sizes, operation and result codes,
// and the types passed between the front end and the decision engine. No dependencies.
package mdt_pkg;

  localparam int NumPatterns  = 8;
  localparam int PatternLen   = 8;
  localparam int PositionBits = 16;
  localparam int SlotBits     = 3;
  localparam int IdxBits      = 3;
  localparam int LenBits      = 4;
  localparam int CuBits       = 16;

  localparam logic [1:0] OP_PAT_CHAR = 2'd0;
  localparam logic [1:0] OP_PAT_LEN  = 2'd1;
  localparam logic [1:0] OP_STR_CHAR = 2'd2;
  localparam logic [1:0] OP_STR_END  = 2'd3;

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_SPACER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  // item passed from the front end to the engine
  typedef struct packed {
    logic [1:0]          op;
    logic [SlotBits-1:0] slot;
    logic [IdxBits-1:0]  idx;
    logic [CuBits-1:0]   cu;
    logic [LenBits-1:0]  plen;
    logic                spacer;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]          kind;
    logic [15:0]         start;
    logic [15:0]         len;
    logic [SlotBits-1:0] slot;
    logic                ovf;
    logic                last;
  } res_t;

endpackage

// ===== rtl/mdt_front.sv =====
// Front end of the tokenizer: accepts input items, saturates pattern lengths,
// and holds them in a two-entry queue for the engine. Depends on mdt_pkg.
module mdt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  mdt_pkg::cmd_t cmd_in,
  output logic          cmd_valid,
  output mdt_pkg::cmd_t cmd_out,
  input  logic          cmd_take
);

  mdt_pkg::cmd_t q [2];
  logic          rd_ptr;
  logic          wr_ptr;
  logic [1:0]    count;
  mdt_pkg::cmd_t cls;
  logic          do_wr;
  logic          do_rd;

  // classify: clamp an oversized length
  always_comb begin
    cls = cmd_in;
    if (cmd_in.plen > mdt_pkg::LenBits'(mdt_pkg::PatternLen))
      cls.plen = mdt_pkg::LenBits'(mdt_pkg::PatternLen);
  end

  assign full      = count[1];
  assign cmd_valid = count != 2'd0;
  assign cmd_out   = q[rd_ptr];
  assign do_wr     = push && !full;
  assign do_rd     = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_wr)
      q[wr_ptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr)
        wr_ptr <= !wr_ptr;
      if (do_rd)
        rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== rtl/mdt_engine.sv =====
// Decision engine: pattern table, lookahead window and the token sequencer
// that emits results into an output register. Depends on mdt_pkg.
module mdt_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          keep_nulls,
  input  logic          cmd_valid,
  input  mdt_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output mdt_pkg::res_t res,
  input  logic          res_take
);

  localparam int NP = mdt_pkg::NumPatterns;
  localparam int PL = mdt_pkg::PatternLen;
  localparam int PB = mdt_pkg::PositionBits;
  localparam int SB = mdt_pkg::SlotBits;
  localparam int LB = mdt_pkg::LenBits;
  localparam int CB = mdt_pkg::CuBits;
  localparam logic [PB-1:0] PosLimit = {PB{1'b1}};

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_SPACER = 3'd2;
  localparam logic [2:0] ST_TAIL   = 3'd3;
  localparam logic [2:0] ST_ENDM   = 3'd4;

  logic [CB-1:0] pchars [NP][PL];
  logic [LB-1:0] plens  [NP];
  logic          pspc   [NP];
  logic [CB-1:0] win    [PL];
  logic [LB-1:0] wcount;
  logic [PB-1:0] dpos;
  logic [PB-1:0] tbegin;
  logic          ovf_flag;
  logic [2:0]    state;
  logic          at_end;
  logic [SB-1:0] hit_slot;
  logic          out_full;
  logic          idle_s;

  // match vector and first-match pick
  logic [NP-1:0] match;
  logic          sep_hit, spc_hit;
  logic [SB-1:0] sep_slot, spc_slot;
  logic [LB-1:0] hit_len;
  logic          hit_spc;

  always_comb begin
    for (int s = 0; s < NP; s++) begin
      match[s] = plens[s] != '0 && plens[s] <= wcount;
      for (int i = 0; i < PL; i++)
        if (LB'(i) < plens[s] && pchars[s][i] != win[i])
          match[s] = 1'b0;
    end
    sep_hit = 1'b0; spc_hit = 1'b0; sep_slot = '0; spc_slot = '0;
    for (int s = NP - 1; s >= 0; s--) begin
      if (match[s] && !pspc[s]) begin
        sep_hit = 1'b1; sep_slot = SB'(s);
      end
      if (match[s] && pspc[s]) begin
        spc_hit = 1'b1; spc_slot = SB'(s);
      end
    end
    hit_spc = !sep_hit;
    hit_len = sep_hit ? plens[sep_slot] : plens[spc_slot];
  end

  logic any_hit;
  logic [LB-1:0] adv;
  logic emit_tok;
  assign any_hit  = sep_hit || spc_hit;
  assign adv      = any_hit ? hit_len : LB'(1);
  assign emit_tok = dpos > tbegin || keep_nulls;
  assign idle_s   = dpos == '0 && wcount == '0 && !ovf_flag;

  assign cmd_take  = state == ST_IDLE && cmd_valid;
  assign res_valid = out_full;

  logic can_out;
  assign can_out = !out_full || res_take;

  // pattern table writes
  always_ff @(posedge clk) begin
    if (cmd_take && idle_s && cmd.op == mdt_pkg::OP_PAT_CHAR)
      pchars[cmd.slot][cmd.idx] <= cmd.cu;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NP; s++) begin
        plens[s] <= '0;
        pspc[s]  <= 1'b0;
      end
    end else if (cmd_take && idle_s && cmd.op == mdt_pkg::OP_PAT_LEN) begin
      plens[cmd.slot] <= cmd.plen;
      pspc[cmd.slot]  <= cmd.spacer;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin : seq
    logic res_load;
    res_load = 1'b0;
    if (rst) begin
      state    <= ST_IDLE;
      wcount   <= '0;
      dpos     <= '0;
      tbegin   <= '0;
      ovf_flag <= 1'b0;
      out_full <= 1'b0;
      at_end   <= 1'b0;
      hit_slot <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            if (cmd.op == mdt_pkg::OP_STR_CHAR) begin
              if (dpos + PB'(wcount) >= PosLimit) begin
                ovf_flag <= 1'b1;
              end else begin
                win[wcount[$clog2(PL)-1:0]] <= cmd.cu;
                wcount <= wcount + LB'(1);
                at_end <= 1'b0;
                if (wcount + LB'(1) >= LB'(PL))
                  state <= ST_DECIDE;
              end
            end else if (cmd.op == mdt_pkg::OP_STR_END) begin
              at_end <= 1'b1;
              state  <= (wcount != '0) ? ST_DECIDE : ST_TAIL;
            end
          end
        end
        ST_DECIDE: begin
          if (can_out) begin
            // shift window by adv
            for (int i = 0; i < PL; i++)
              if (i + int'(adv) < PL)
                win[i] <= win[i + int'(adv)];
            wcount <= wcount - adv;
            dpos   <= dpos + PB'(adv);
            if (any_hit) begin
              tbegin   <= dpos + PB'(adv);
              hit_slot <= spc_slot;
            end
            if (any_hit && emit_tok) begin
              res_load  = 1'b1;
              res.kind  <= mdt_pkg::KIND_TEXT;
              res.start <= 16'(tbegin);
              res.len   <= 16'(dpos - tbegin);
              res.slot  <= '0;
              res.ovf   <= 1'b0;
              res.last  <= !hit_spc && !at_end;
            end
            if (any_hit && hit_spc)
              state <= ST_SPACER;
            else if (at_end && wcount != adv)
              state <= ST_DECIDE;
            else if (at_end)
              state <= ST_TAIL;
            else
              state <= ST_IDLE;
          end
        end
        ST_SPACER: begin
          if (can_out) begin
            res_load  = 1'b1;
            res.kind  <= mdt_pkg::KIND_SPACER;
            res.start <= '0;
            res.len   <= '0;
            res.slot  <= hit_slot;
            res.ovf   <= 1'b0;
            res.last  <= !at_end;
            if (!at_end)
              state <= ST_IDLE;
            else if (wcount != '0)
              state <= ST_DECIDE;
            else
              state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (dpos <= tbegin) begin
            state <= ST_ENDM;
          end else if (can_out) begin
            res_load  = 1'b1;
            res.kind  <= mdt_pkg::KIND_TEXT;
            res.start <= 16'(tbegin);
            res.len   <= 16'(dpos - tbegin);
            res.slot  <= '0;
            res.ovf   <= 1'b0;
            res.last  <= 1'b0;
            state     <= ST_ENDM;
          end
        end
        ST_ENDM: begin
          if (can_out) begin
            res_load  = 1'b1;
            res.kind  <= mdt_pkg::KIND_END;
            res.start <= '0;
            res.len   <= '0;
            res.slot  <= '0;
            res.ovf   <= ovf_flag;
            res.last  <= 1'b1;
            wcount    <= '0;
            dpos      <= '0;
            tbegin    <= '0;
            ovf_flag  <= 1'b0;
            at_end    <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // output register: loaded by the sequencer, emptied by a transfer out
      out_full <= res_load || (out_full && !res_take);
    end
  end

endmodule

// ===== rtl/multi_delimiter_tokenizer_core.sv =====
// Top level of the multi-delimiter tokenizer: front-end queue, decision engine
// and the keep_nulls register. Depends on mdt_pkg, mdt_front and mdt_engine.
//
// Usage: items enter on the push/full queue interface (operation, slot, char_index,
// code_unit, pattern_length, is_spacer). Pattern loads (operations 0 and 1) are
// applied only between strings. Results leave on the empty/pop interface; the oldest
// result sits on the ports while empty is low, and last marks the final result
// of an input item.
// keep_nulls is written through cfg_valid/cfg_ready/cfg_data; the user must write
// it only while idle, as the block itself does not enforce this.
// An item passes through the input queue to the engine's sequencer; each result
// is held in the output register. The engine takes a new item only when idle: a
// string char goes into the window, a full window adds a decision state and each
// spacer result a spacer state; end of string runs decisions until the window is
// empty (at most one per unit), spacer states, then the tail and end states.
// Reset clears the pattern lengths (all slots disabled), the window, the
// positions, keep_nulls and both queues. When the receiver stalls, the output
// register holds its result, the engine waits, and the two-entry input queue
// fills and raises full.
module multi_delimiter_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [2:0]  slot,
  input  logic [2:0]  char_index,
  input  logic [15:0] code_unit,
  input  logic [3:0]  pattern_length,
  input  logic        is_spacer,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [2:0]  spacer_slot,
  output logic        overflow,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  mdt_pkg::cmd_t cmd_in;
  mdt_pkg::cmd_t cmd_q;
  mdt_pkg::res_t res;
  logic          cmd_valid;
  logic          cmd_take;
  logic          res_valid;
  logic          keep_nulls;

  assign cmd_in = '{op: operation, slot: slot, idx: char_index, cu: code_unit,
                    plen: pattern_length, spacer: is_spacer};

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst)
      keep_nulls <= 1'b0;
    else if (cfg_valid && cfg_ready)
      keep_nulls <= cfg_data;
  end

  mdt_front u_front (
    .clk, .rst, .push, .full, .cmd_in,
    .cmd_valid, .cmd_out(cmd_q), .cmd_take
  );

  mdt_engine u_engine (
    .clk, .rst, .keep_nulls, .cmd_valid, .cmd(cmd_q), .cmd_take,
    .res_valid, .res, .res_take(pop)
  );

  assign empty        = !res_valid;
  assign kind         = res.kind;
  assign token_start  = res.start;
  assign token_length = res.len;
  assign spacer_slot  = res.slot;
  assign overflow     = res.ovf;
  assign last         = res.last;

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == mdt_pkg::KIND_END) |-> last)
    else $error("end marker without last");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(token_start)))
    else $error("result changed while stalled");
  a_spacer_fields: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == mdt_pkg::KIND_SPACER) |-> (token_length == 16'd0))
    else $error("spacer result carries a length");
`endif

endmodule

// ===== tb/multi_delimiter_tokenizer_core_tb.sv =====
// Testbench for multi_delimiter_tokenizer_core: loads pattern tables, streams strings and
// checks every token descriptor against a built-in predictor. Depends on mdt_pkg and the RTL.
`timescale 1ns / 1ps

module multi_delimiter_tokenizer_core_tb;

  localparam int PosLimit = (1 << mdt_pkg::PositionBits) - 1;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  slot;
    logic [2:0]  idx;
    logic [15:0] cu;
    logic [3:0]  plen;
    logic        spacer;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [2:0]  slot;
    logic        ovf;
    logic        last;
  } token_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [1:0] operation = '0;
  logic [2:0] slot = '0;
  logic [2:0] char_index = '0;
  logic [15:0] code_unit = '0;
  logic [3:0] pattern_length = '0;
  logic is_spacer = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] kind;
  logic [15:0] token_start, token_length;
  logic [2:0] spacer_slot;
  logic overflow, last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  multi_delimiter_tokenizer_core i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .slot(slot), .char_index(char_index),
    .code_unit(code_unit), .pattern_length(pattern_length), .is_spacer(is_spacer),
    .empty(empty), .pop(pop), .kind(kind), .token_start(token_start),
    .token_length(token_length), .spacer_slot(spacer_slot), .overflow(overflow),
    .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] pat_units [mdt_pkg::NumPatterns][mdt_pkg::PatternLen];
  logic [3:0]  pat_len [mdt_pkg::NumPatterns];
  logic        pat_spacer [mdt_pkg::NumPatterns];
  logic [15:0] window [mdt_pkg::PatternLen];
  int unsigned win_fill, head_pos, text_begin;
  logic        dropped, keep_empty;

  token_t tokens_due[$];
  int unsigned mismatches = 0, tokens_seen = 0, items_sent = 0, idle_cycles = 0;
  int unsigned strings_done = 0;

  function automatic void add_token(ref token_t q[$], input logic [1:0] k,
                                    input int unsigned st, input int unsigned ln,
                                    input int unsigned sl, input logic ov);
    token_t t;
    if (q.size() >= 16) return;
    t.kind = k; t.start = st[15:0]; t.len = ln[15:0]; t.slot = sl[2:0];
    t.ovf = ov; t.last = 1'b0;
    q.push_back(t);
  endfunction

  function automatic bit slot_hits(int s);
    if (pat_len[s] == 0 || pat_len[s] > win_fill) return 0;
    for (int i = 0; i < pat_len[s]; i++)
      if (pat_units[s][i] != window[i]) return 0;
    return 1;
  endfunction

  function automatic void skip_units(int unsigned k);
    if (k > win_fill) k = win_fill;
    for (int i = 0; i < mdt_pkg::PatternLen; i++)
      if (i + k < mdt_pkg::PatternLen) window[i] = window[i + k];
    win_fill -= k;
    head_pos += k;
  endfunction

  // one decision at the window head: separators first, then spacers
  function automatic void decide_head(ref token_t q[$]);
    for (int pass = 0; pass < 2; pass++)
      for (int s = 0; s < mdt_pkg::NumPatterns; s++) begin
        if (pat_spacer[s] != pass || !slot_hits(s)) continue;
        if (head_pos > text_begin || keep_empty)
          add_token(q, mdt_pkg::KIND_TEXT, text_begin, head_pos - text_begin, 0, 0);
        if (pass == 1) add_token(q, mdt_pkg::KIND_SPACER, 0, 0, s, 0);
        skip_units(pat_len[s]);
        text_begin = head_pos;
        return;
      end
    skip_units(1);
  endfunction

  function automatic void predict_tokens(item_t it);
    token_t q[$];
    bit idle;
    idle = (head_pos == 0 && win_fill == 0 && !dropped);
    case (it.op)
      mdt_pkg::OP_PAT_CHAR: if (idle) pat_units[it.slot][it.idx] = it.cu;
      mdt_pkg::OP_PAT_LEN: if (idle) begin
        pat_len[it.slot] = (it.plen > mdt_pkg::PatternLen) ?
                           4'(mdt_pkg::PatternLen) : it.plen;
        pat_spacer[it.slot] = it.spacer;
      end
      mdt_pkg::OP_STR_CHAR: begin
        if (head_pos + win_fill >= PosLimit) dropped = 1'b1;
        else begin
          window[win_fill] = it.cu;
          win_fill++;
          if (win_fill >= mdt_pkg::PatternLen) decide_head(q);
        end
      end
      default: begin
        while (win_fill > 0) decide_head(q);
        if (head_pos > text_begin)
          add_token(q, mdt_pkg::KIND_TEXT, text_begin, head_pos - text_begin, 0, 0);
        add_token(q, mdt_pkg::KIND_END, 0, 0, 0, dropped);
        win_fill = 0; head_pos = 0; text_begin = 0; dropped = 1'b0;
      end
    endcase
    if (q.size() > 0) q[q.size() - 1].last = 1'b1;
    foreach (q[i]) tokens_due.push_back(q[i]);
  endfunction

  // sender: bursts with random gaps, one item per transfer
  int burst_left = 0;
  task automatic send_item(item_t it);
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    push <= 1'b1;
    {operation, slot, char_index, code_unit, pattern_length, is_spacer} <= it;
    do @(posedge clk); while (full);
    predict_tokens(it);
    items_sent++;
    burst_left--;
    // keep push high if the next call comes in this same step
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    stop_sending();
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_keep_nulls(logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    keep_empty = v;
  endtask

  function automatic item_t mk(logic [1:0] op, int s, int i, int c, int pl, int sp);
    item_t it;
    it.op = op; it.slot = s[2:0]; it.idx = i[2:0]; it.cu = c[15:0];
    it.plen = pl[3:0]; it.spacer = sp[0];
    return it;
  endfunction

  task automatic load_pattern(int s, int len, logic sp, logic [15:0] u []);
    for (int i = 0; i < len; i++)
      send_item(mk(mdt_pkg::OP_PAT_CHAR, s, i, u[i], 0, 0));
    send_item(mk(mdt_pkg::OP_PAT_LEN, s, 0, 0, len, sp));
  endtask

  // result side: stall pattern, compare with the oldest expectation
  logic [3:0] stall_phase = '0;
  logic stall_mode = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      token_t exp_t, got;
      stall_phase <= stall_phase + 1'b1;
      if (stall_phase == 0) stall_mode <= $urandom_range(0, 2) != 0;
      pop <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      if (pop && !empty) begin
        got = {kind, token_start, token_length, spacer_slot, overflow, last};
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_t = tokens_due.pop_front();
          if (got != exp_t) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch kind %0d/%0d start %0d/%0d len %0d/%0d slot %0d/%0d ovf %0d/%0d last %0d/%0d",
                exp_t.kind, got.kind, exp_t.start, got.start, exp_t.len, got.len,
                exp_t.slot, got.slot, exp_t.ovf, got.ovf, exp_t.last, got.last);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst ||
        (tokens_due.size() == 0 && !push)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // random string over a small alphabet so patterns hit often
  task automatic random_string(int n);
    for (int i = 0; i < n; i++) begin
      int c;
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3);
      send_item(mk(mdt_pkg::OP_STR_CHAR, $urandom_range(0, 7), $urandom_range(0, 7), c,
                   $urandom_range(0, 15), $urandom_range(0, 1)));
      if ($urandom_range(0, 15) == 0)  // ignored mid-string load
        send_item(mk(2'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 7),
                     $urandom_range(0, 3), $urandom_range(0, 15), $urandom_range(0, 1)));
    end
    send_item(mk(mdt_pkg::OP_STR_END, $urandom_range(0, 7), $urandom_range(0, 7),
                 $urandom_range(0, 65535), $urandom_range(0, 15), $urandom_range(0, 1)));
    strings_done++;
  endtask

  // directed rows: string units walked by a loop, ends checked by typed expectation
  typedef struct { item_t it; bit typed; token_t want; } row_t;

  initial begin
    row_t rows [$];
    row_t r;
    logic [15:0] u [];
    for (int s = 0; s < mdt_pkg::NumPatterns; s++) begin
      pat_len[s] = 0; pat_spacer[s] = 0;
    end
    win_fill = 0; head_pos = 0; text_begin = 0; dropped = 0; keep_empty = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes and a short string
    u = new[8];
    foreach (u[i]) u[i] = 16'hFFFF;
    load_pattern(0, 8, 1'b0, u);               // full-length separator of all ones
    u[0] = 16'h0000;
    load_pattern(7, 1, 1'b1, u);               // one-unit spacer of zero
    send_item(mk(mdt_pkg::OP_PAT_LEN, 6, 0, 0, 15, 1)); // length saturates
    send_item(mk(mdt_pkg::OP_PAT_LEN, 6, 0, 0, 0, 0));  // disable again
    r.typed = 1; r.it = mk(mdt_pkg::OP_STR_END, 7, 7, 16'hFFFF, 15, 1);
    r.want = {mdt_pkg::KIND_END, 16'd0, 16'd0, 3'd0, 1'b0, 1'b1};
    rows.push_back(r);
    foreach (rows[i]) begin
      send_item(rows[i].it);
      if (rows[i].typed) begin
        // replace predicted expectation by the typed one
        void'(tokens_due.pop_back());
        tokens_due.push_back(rows[i].want);
      end
    end
    foreach (u[i]) u[i] = 16'hFFFF;
    for (int i = 0; i < 3; i++) send_item(mk(mdt_pkg::OP_STR_CHAR, 0, 0, 16'h0041, 0, 0));
    for (int i = 0; i < 8; i++) send_item(mk(mdt_pkg::OP_STR_CHAR, 0, 0, 16'hFFFF, 0, 0));
    send_item(mk(mdt_pkg::OP_STR_CHAR, 0, 0, 16'h0000, 0, 0));
    send_item(mk(mdt_pkg::OP_STR_CHAR, 0, 0, 16'h0000, 0, 0));
    send_item(mk(mdt_pkg::OP_STR_END, 0, 0, 0, 0, 0));
    wait_drained();
    write_keep_nulls(1'b1);

    // random phases, each with a fresh pattern table and setting
    for (int ph = 0; ph < 5; ph++) begin
      for (int s = 0; s < mdt_pkg::NumPatterns; s++) begin
        int len;
        len = (s < 3) ? $urandom_range(1, 3) : $urandom_range(0, 8);
        u = new[8];
        foreach (u[i]) u[i] = 16'($urandom_range(0, 3));
        load_pattern(s, (len == 0) ? 1 : len, 1'($urandom_range(0, 1)), u);
        if (len == 0) send_item(mk(mdt_pkg::OP_PAT_LEN, s, 0, 0, 0, 0));
      end
      for (int k = 0; k < 4; k++) random_string($urandom_range(0, 14));
      wait_drained();
      write_keep_nulls(ph[0]);
    end
    wait_drained();

    $display("sent %0d items in %0d strings, checked %0d results, %0d mismatches",
             items_sent, strings_done, tokens_seen, mismatches);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
